// ----- sv/qra_pkg.sv -----
// Package for the quaternion rotation accumulator.
// Holds fixed-point constants, sequencer operation codes and the MAC program.
// No dependencies.
package qra_pkg;

  localparam logic [63:0] HALF_Q30    = 64'd536870912;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [29:0] FOLD_LIMIT  = 30'd536870912;
  localparam logic [31:0] RAD_K_LO    = 32'd1597009354;
  localparam logic [31:0] RAD_K_HI    = 32'd20;
  localparam logic [31:0] DEG_K_LO    = 32'd1527099483;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [63:0] SQRT_BIT0   = 64'h4000_0000_0000_0000;

  typedef logic [4:0] src_sel_t;
  typedef logic [3:0] dst_sel_t;
  typedef logic [1:0] mac_mode_t;

  typedef struct packed {
    src_sel_t  a;
    src_sel_t  b;
    dst_sel_t  d;
    mac_mode_t mode;
  } mac_op_t;

  localparam mac_mode_t MAC_SET = 2'd0;
  localparam mac_mode_t MAC_ADD = 2'd1;
  localparam mac_mode_t MAC_SUB = 2'd2;

  localparam src_sel_t SRC_SX  = 5'd0;
  localparam src_sel_t SRC_CX  = 5'd1;
  localparam src_sel_t SRC_SY  = 5'd2;
  localparam src_sel_t SRC_CY  = 5'd3;
  localparam src_sel_t SRC_SZ  = 5'd4;
  localparam src_sel_t SRC_CZ  = 5'd5;
  localparam src_sel_t SRC_TA  = 5'd6;
  localparam src_sel_t SRC_TB  = 5'd7;
  localparam src_sel_t SRC_TC  = 5'd8;
  localparam src_sel_t SRC_TD  = 5'd9;
  localparam src_sel_t SRC_Q1X = 5'd10;
  localparam src_sel_t SRC_Q1Y = 5'd11;
  localparam src_sel_t SRC_Q1Z = 5'd12;
  localparam src_sel_t SRC_Q1W = 5'd13;
  localparam src_sel_t SRC_OX  = 5'd14;
  localparam src_sel_t SRC_OY  = 5'd15;
  localparam src_sel_t SRC_OZ  = 5'd16;
  localparam src_sel_t SRC_OW  = 5'd17;
  localparam src_sel_t SRC_NX  = 5'd18;
  localparam src_sel_t SRC_NY  = 5'd19;
  localparam src_sel_t SRC_NZ  = 5'd20;

  localparam dst_sel_t DST_TA  = 4'd0;
  localparam dst_sel_t DST_TB  = 4'd1;
  localparam dst_sel_t DST_TC  = 4'd2;
  localparam dst_sel_t DST_TD  = 4'd3;
  localparam dst_sel_t DST_Q1X = 4'd4;
  localparam dst_sel_t DST_Q1Y = 4'd5;
  localparam dst_sel_t DST_Q1Z = 4'd6;
  localparam dst_sel_t DST_Q1W = 4'd7;
  localparam dst_sel_t DST_P0  = 4'd8;
  localparam dst_sel_t DST_P1  = 4'd9;
  localparam dst_sel_t DST_P2  = 4'd10;
  localparam dst_sel_t DST_P3  = 4'd11;

  // program layout: Euler q1, axis-angle q1, Hamilton product
  localparam logic [4:0] PC_EUL_FIRST  = 5'd0;
  localparam logic [4:0] PC_EUL_LAST   = 5'd11;
  localparam logic [4:0] PC_AX_FIRST   = 5'd12;
  localparam logic [4:0] PC_PROD_FIRST = 5'd15;
  localparam logic [4:0] PC_PROD_LAST  = 5'd30;

  localparam logic [3:0] K_SIN_LAST = 4'd4;
  localparam logic [3:0] K_COS_LAST = 4'd10;

  function automatic mac_op_t mac_rom(input logic [4:0] pc);
    mac_op_t op;
    op = '{SRC_SX, SRC_SX, DST_TA, MAC_SET};
    unique case (pc)
      5'd0:  op = '{SRC_CZ,  SRC_SX, DST_TA,  MAC_SET};
      5'd1:  op = '{SRC_SZ,  SRC_CX, DST_TB,  MAC_SET};
      5'd2:  op = '{SRC_CZ,  SRC_CX, DST_TC,  MAC_SET};
      5'd3:  op = '{SRC_SZ,  SRC_SX, DST_TD,  MAC_SET};
      5'd4:  op = '{SRC_TA,  SRC_CY, DST_Q1X, MAC_SET};
      5'd5:  op = '{SRC_TB,  SRC_SY, DST_Q1X, MAC_SUB};
      5'd6:  op = '{SRC_TC,  SRC_SY, DST_Q1Y, MAC_SET};
      5'd7:  op = '{SRC_TD,  SRC_CY, DST_Q1Y, MAC_ADD};
      5'd8:  op = '{SRC_TB,  SRC_CY, DST_Q1Z, MAC_SET};
      5'd9:  op = '{SRC_TA,  SRC_SY, DST_Q1Z, MAC_SUB};
      5'd10: op = '{SRC_TC,  SRC_CY, DST_Q1W, MAC_SET};
      5'd11: op = '{SRC_TD,  SRC_SY, DST_Q1W, MAC_ADD};
      5'd12: op = '{SRC_NX,  SRC_SX, DST_Q1X, MAC_SET};
      5'd13: op = '{SRC_NY,  SRC_SX, DST_Q1Y, MAC_SET};
      5'd14: op = '{SRC_NZ,  SRC_SX, DST_Q1Z, MAC_SET};
      5'd15: op = '{SRC_Q1W, SRC_OX, DST_P0,  MAC_SET};
      5'd16: op = '{SRC_Q1X, SRC_OW, DST_P0,  MAC_ADD};
      5'd17: op = '{SRC_Q1Y, SRC_OZ, DST_P0,  MAC_ADD};
      5'd18: op = '{SRC_Q1Z, SRC_OY, DST_P0,  MAC_SUB};
      5'd19: op = '{SRC_Q1W, SRC_OY, DST_P1,  MAC_SET};
      5'd20: op = '{SRC_Q1Y, SRC_OW, DST_P1,  MAC_ADD};
      5'd21: op = '{SRC_Q1Z, SRC_OX, DST_P1,  MAC_ADD};
      5'd22: op = '{SRC_Q1X, SRC_OZ, DST_P1,  MAC_SUB};
      5'd23: op = '{SRC_Q1W, SRC_OZ, DST_P2,  MAC_SET};
      5'd24: op = '{SRC_Q1Z, SRC_OW, DST_P2,  MAC_ADD};
      5'd25: op = '{SRC_Q1X, SRC_OY, DST_P2,  MAC_ADD};
      5'd26: op = '{SRC_Q1Y, SRC_OX, DST_P2,  MAC_SUB};
      5'd27: op = '{SRC_Q1W, SRC_OW, DST_P3,  MAC_SET};
      5'd28: op = '{SRC_Q1X, SRC_OX, DST_P3,  MAC_SUB};
      5'd29: op = '{SRC_Q1Y, SRC_OY, DST_P3,  MAC_SUB};
      5'd30: op = '{SRC_Q1Z, SRC_OZ, DST_P3,  MAC_SUB};
      default: op = '{SRC_SX, SRC_SX, DST_TA, MAC_SET};
    endcase
    return op;
  endfunction

  // Taylor divisors: sine steps first, then cosine steps
  function automatic logic [7:0] taylor_div(input logic [3:0] idx);
    logic [7:0] k;
    k = 8'd2;
    unique case (idx)
      4'd0:  k = 8'd110;
      4'd1:  k = 8'd72;
      4'd2:  k = 8'd42;
      4'd3:  k = 8'd20;
      4'd4:  k = 8'd6;
      4'd5:  k = 8'd132;
      4'd6:  k = 8'd90;
      4'd7:  k = 8'd56;
      4'd8:  k = 8'd30;
      4'd9:  k = 8'd12;
      default: k = 8'd2;
    endcase
    return k;
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] taylor_recip(input logic [3:0] idx);
    logic [31:0] r;
    r = 32'd2147483648;
    unique case (idx)
      4'd0:  r = 32'd39045157;
      4'd1:  r = 32'd59652323;
      4'd2:  r = 32'd102261126;
      4'd3:  r = 32'd214748364;
      4'd4:  r = 32'd715827882;
      4'd5:  r = 32'd32537631;
      4'd6:  r = 32'd47721858;
      4'd7:  r = 32'd76695844;
      4'd8:  r = 32'd143165576;
      4'd9:  r = 32'd357913941;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/quaternion_rotation_accumulator.sv -----
// Quaternion rotation accumulator top level: sequencer around one shared
// 32x32 multiplier, bit-serial square root and divider. Uses qra_pkg.
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    command, in_degrees, angle_*, rotation_angle, axis_*
// out      output     out_valid / out_ready  quat_x, quat_y, quat_z, quat_w, updated
//
// A skipped axis-angle item goes straight from the check state to the output;
// the length of an update is set by the 32-step square root, run once per
// normalization, and the 32-step divide, run once per normalized component.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register, and the next item is accepted meanwhile.
// rst is synchronous; it sets the orientation to identity and drops out_valid.
module quaternion_rotation_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic               in_degrees,
  input  logic signed [31:0] angle_x,
  input  logic signed [31:0] angle_y,
  input  logic signed [31:0] angle_z,
  input  logic signed [31:0] rotation_angle,
  input  logic signed [31:0] axis_x,
  input  logic signed [31:0] axis_y,
  input  logic signed [31:0] axis_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic signed [31:0] quat_w,
  output logic               updated
);
  import qra_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_PH0  = 5'd2;
  localparam logic [4:0] S_PH1  = 5'd3;
  localparam logic [4:0] S_TH   = 5'd4;
  localparam logic [4:0] S_X2   = 5'd5;
  localparam logic [4:0] S_H0   = 5'd6;
  localparam logic [4:0] S_H1   = 5'd7;
  localparam logic [4:0] S_H2   = 5'd8;
  localparam logic [4:0] S_H3   = 5'd9;
  localparam logic [4:0] S_SN   = 5'd10;
  localparam logic [4:0] S_SC   = 5'd11;
  localparam logic [4:0] S_MAC  = 5'd12;
  localparam logic [4:0] S_NM0  = 5'd13;
  localparam logic [4:0] S_NSH  = 5'd14;
  localparam logic [4:0] S_NSQ  = 5'd15;
  localparam logic [4:0] S_NSR  = 5'd16;
  localparam logic [4:0] S_NDI  = 5'd17;
  localparam logic [4:0] S_NDV  = 5'd18;
  localparam logic [4:0] S_NEND = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;

  logic [4:0] state;

  // captured item
  logic               cmd_r;
  logic               deg_r;
  logic signed [31:0] ang_x_r, ang_y_r, ang_z_r, rot_r;

  // orientation
  logic signed [31:0] o_x, o_y, o_z, o_w;
  logic               upd_r;

  // sine/cosine unit
  logic [1:0]  j;
  logic [63:0] ph_acc;
  logic [31:0] phase_r;
  logic [30:0] theta, x2, term, vv, q0, sn;
  logic [8:0]  rr;
  logic [3:0]  kidx;
  logic signed [31:0] s_x, c_x, s_y, c_y, s_z, c_z;

  // MAC working set
  logic [4:0] pc;
  logic signed [35:0] t_a, t_b, t_c, t_d;
  logic signed [35:0] q1_x, q1_y, q1_z, q1_w;
  logic signed [35:0] p0, p1, p2, p3;

  // normalizer
  logic        norm_quat;
  logic [35:0] mag [4];
  logic [3:0]  sg;
  logic [35:0] mx;
  logic [1:0]  ni;
  logic [63:0] sum_sq, rx, res, bitv;
  logic [31:0] rem, quo;
  logic [4:0]  cnt;
  logic signed [31:0] nrm [4];

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, rnd_w;
  logic [33:0] rnd;

  logic signed [31:0] ang_sel;
  logic [31:0] ang_mag;
  logic [63:0] ph_full, ph_neg;
  logic [1:0]  quad;
  logic        fold;
  logic [30:0] tf;
  logic [7:0]  kdiv;
  logic [30:0] qq, bs, bc;
  logic signed [31:0] s_val, c_val;

  mac_op_t mop;
  logic signed [35:0] src_bus [32];
  logic signed [35:0] dst_bus [16];
  logic signed [35:0] src_a, src_b, mac_term, mac_cur, mac_new;
  logic [31:0] mac_ma, mac_mb;
  logic        mac_neg;

  logic [35:0] mg0, mg1, mg2, mg3, mg_max01, mg_max23, mg_max;
  logic [63:0] sq_try;
  logic [61:0] div_num;
  logic [32:0] rem2;
  logic        div_ge;
  logic [31:0] quo_new;
  logic [1:0]  nlast;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    unique case (j)
      2'd0:    ang_sel = cmd_r ? rot_r : ang_x_r;
      2'd1:    ang_sel = ang_y_r;
      default: ang_sel = ang_z_r;
    endcase
  end
  assign ang_mag = ang_sel[31] ? 32'(-ang_sel) : 32'(ang_sel);
  assign ph_full = ph_acc + {prod[31:0], 32'd0};
  assign ph_neg  = ~ph_full + 64'd1;

  assign quad = phase_r[31:30];
  assign fold = phase_r[29:0] > FOLD_LIMIT;
  assign tf   = fold ? (ONE_Q30 - {1'b0, phase_r[29:0]}) : {1'b0, phase_r[29:0]};
  assign kdiv = taylor_div(kidx);
  assign qq   = q0 + ((rr >= {1'b0, kdiv}) ? 31'd1 : 31'd0);

  assign bs = fold ? term : sn;
  assign bc = fold ? sn : term;
  always_comb begin
    unique case (quad)
      2'd0: begin
        s_val = {1'b0, bs};
        c_val = {1'b0, bc};
      end
      2'd1: begin
        s_val = {1'b0, bc};
        c_val = -$signed({1'b0, bs});
      end
      2'd2: begin
        s_val = -$signed({1'b0, bs});
        c_val = -$signed({1'b0, bc});
      end
      default: begin
        s_val = -$signed({1'b0, bc});
        c_val = {1'b0, bs};
      end
    endcase
  end

  // operand buses for the MAC program
  assign mop = mac_rom(pc);
  always_comb begin
    for (int k = 0; k < 32; k++) src_bus[k] = '0;
    src_bus[SRC_SX]  = 36'(s_x);
    src_bus[SRC_CX]  = 36'(c_x);
    src_bus[SRC_SY]  = 36'(s_y);
    src_bus[SRC_CY]  = 36'(c_y);
    src_bus[SRC_SZ]  = 36'(s_z);
    src_bus[SRC_CZ]  = 36'(c_z);
    src_bus[SRC_TA]  = t_a;
    src_bus[SRC_TB]  = t_b;
    src_bus[SRC_TC]  = t_c;
    src_bus[SRC_TD]  = t_d;
    src_bus[SRC_Q1X] = q1_x;
    src_bus[SRC_Q1Y] = q1_y;
    src_bus[SRC_Q1Z] = q1_z;
    src_bus[SRC_Q1W] = q1_w;
    src_bus[SRC_OX]  = 36'(o_x);
    src_bus[SRC_OY]  = 36'(o_y);
    src_bus[SRC_OZ]  = 36'(o_z);
    src_bus[SRC_OW]  = 36'(o_w);
    src_bus[SRC_NX]  = 36'(nrm[0]);
    src_bus[SRC_NY]  = 36'(nrm[1]);
    src_bus[SRC_NZ]  = 36'(nrm[2]);
  end
  always_comb begin
    for (int k = 0; k < 16; k++) dst_bus[k] = '0;
    dst_bus[DST_TA]  = t_a;
    dst_bus[DST_TB]  = t_b;
    dst_bus[DST_TC]  = t_c;
    dst_bus[DST_TD]  = t_d;
    dst_bus[DST_Q1X] = q1_x;
    dst_bus[DST_Q1Y] = q1_y;
    dst_bus[DST_Q1Z] = q1_z;
    dst_bus[DST_Q1W] = q1_w;
    dst_bus[DST_P0]  = p0;
    dst_bus[DST_P1]  = p1;
    dst_bus[DST_P2]  = p2;
    dst_bus[DST_P3]  = p3;
  end
  assign src_a   = src_bus[mop.a];
  assign src_b   = src_bus[mop.b];
  assign mac_ma  = src_a[35] ? 32'(-src_a) : 32'(src_a);
  assign mac_mb  = src_b[35] ? 32'(-src_b) : 32'(src_b);
  assign mac_neg = src_a[35] ^ src_b[35];
  assign mac_term = mac_neg ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});
  assign mac_cur = dst_bus[mop.d];
  always_comb begin
    case (mop.mode)
      MAC_SET: mac_new = mac_term;
      MAC_ADD: mac_new = mac_cur + mac_term;
      default: mac_new = mac_cur - mac_term;
    endcase
  end

  // shared multiplier
  always_comb begin
    unique case (state)
      S_PH0: begin
        mul_a = ang_mag;
        mul_b = deg_r ? DEG_K_LO : RAD_K_LO;
      end
      S_PH1: begin
        mul_a = ang_mag;
        mul_b = deg_r ? 32'd0 : RAD_K_HI;
      end
      S_TH: begin
        mul_a = {1'b0, tf};
        mul_b = HALF_PI_Q30;
      end
      S_X2: begin
        mul_a = {1'b0, theta};
        mul_b = {1'b0, theta};
      end
      S_H0: begin
        mul_a = {1'b0, x2};
        mul_b = {1'b0, term};
      end
      S_H1: begin
        mul_a = {1'b0, vv};
        mul_b = taylor_recip(kidx);
      end
      S_H2: begin
        mul_a = {1'b0, q0};
        mul_b = {24'd0, kdiv};
      end
      S_SN: begin
        mul_a = {1'b0, theta};
        mul_b = {1'b0, term};
      end
      S_MAC: begin
        mul_a = mac_ma;
        mul_b = mac_mb;
      end
      S_NSQ: begin
        mul_a = {1'b0, mag[ni][30:0]};
        mul_b = {1'b0, mag[ni][30:0]};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end
  assign prod  = mul_a * mul_b;
  assign rnd_w = prod + HALF_Q30;
  assign rnd   = rnd_w[63:30];

  // normalizer datapath
  assign mg0 = p0[35] ? 36'(-p0) : 36'(p0);
  assign mg1 = p1[35] ? 36'(-p1) : 36'(p1);
  assign mg2 = p2[35] ? 36'(-p2) : 36'(p2);
  assign mg3 = p3[35] ? 36'(-p3) : 36'(p3);
  assign mg_max01 = (mg0 > mg1) ? mg0 : mg1;
  assign mg_max23 = (mg2 > mg3) ? mg2 : mg3;
  assign mg_max   = (mg_max01 > mg_max23) ? mg_max01 : mg_max23;
  assign sq_try   = res + bitv;
  assign div_num  = {mag[ni][30:0], 30'd0} + {31'd0, res[31:1]};
  assign rem2     = {rem, quo[31]};
  assign div_ge   = rem2 >= {1'b0, res[31:0]};
  assign quo_new  = {quo[30:0], div_ge};
  assign nlast    = norm_quat ? 2'd3 : 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      o_x       <= '0;
      o_y       <= '0;
      o_z       <= '0;
      o_w       <= 32'sd1073741824;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= command;
            deg_r   <= in_degrees;
            ang_x_r <= angle_x;
            ang_y_r <= angle_y;
            ang_z_r <= angle_z;
            rot_r   <= rotation_angle;
            p0      <= 36'(axis_x);
            p1      <= 36'(axis_y);
            p2      <= 36'(axis_z);
            p3      <= '0;
            state   <= S_CHK;
          end
        end
        S_CHK: begin
          j <= 2'd0;
          if (cmd_r) begin
            if (rot_r == 32'sd0 || (p0 == 36'sd0 && p1 == 36'sd0 && p2 == 36'sd0)) begin
              upd_r <= 1'b0;
              state <= S_OUT;
            end else begin
              upd_r     <= 1'b1;
              norm_quat <= 1'b0;
              state     <= S_NM0;
            end
          end else begin
            upd_r <= 1'b1;
            state <= S_PH0;
          end
        end
        S_PH0: begin
          ph_acc <= prod;
          state  <= S_PH1;
        end
        S_PH1: begin
          phase_r <= ang_sel[31] ? ph_neg[59:28] : ph_full[59:28];
          state   <= S_TH;
        end
        S_TH: begin
          theta <= rnd[30:0];
          state <= S_X2;
        end
        S_X2: begin
          x2    <= rnd[30:0];
          term  <= ONE_Q30;
          kidx  <= 4'd0;
          state <= S_H0;
        end
        S_H0: begin
          vv    <= rnd[30:0];
          state <= S_H1;
        end
        S_H1: begin
          q0    <= prod[62:32];
          state <= S_H2;
        end
        S_H2: begin
          rr    <= 9'(({33'd0, vv} - prod));
          state <= S_H3;
        end
        S_H3: begin
          term <= ONE_Q30 - qq;
          if (kidx == K_SIN_LAST) begin
            state <= S_SN;
          end else if (kidx == K_COS_LAST) begin
            state <= S_SC;
          end else begin
            kidx  <= kidx + 4'd1;
            state <= S_H0;
          end
        end
        S_SN: begin
          sn    <= rnd[30:0];
          term  <= ONE_Q30;
          kidx  <= kidx + 4'd1;
          state <= S_H0;
        end
        S_SC: begin
          unique case (j)
            2'd0: begin
              s_x <= s_val;
              c_x <= c_val;
            end
            2'd1: begin
              s_y <= s_val;
              c_y <= c_val;
            end
            default: begin
              s_z <= s_val;
              c_z <= c_val;
            end
          endcase
          if (cmd_r) begin
            q1_w  <= 36'(c_val);
            pc    <= PC_AX_FIRST;
            state <= S_MAC;
          end else if (j != 2'd2) begin
            j     <= j + 2'd1;
            state <= S_PH0;
          end else begin
            pc    <= PC_EUL_FIRST;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          case (mop.d)
            DST_TA:  t_a  <= mac_new;
            DST_TB:  t_b  <= mac_new;
            DST_TC:  t_c  <= mac_new;
            DST_TD:  t_d  <= mac_new;
            DST_Q1X: q1_x <= mac_new;
            DST_Q1Y: q1_y <= mac_new;
            DST_Q1Z: q1_z <= mac_new;
            DST_Q1W: q1_w <= mac_new;
            DST_P0:  p0   <= mac_new;
            DST_P1:  p1   <= mac_new;
            DST_P2:  p2   <= mac_new;
            DST_P3:  p3   <= mac_new;
            default: ;
          endcase
          if (pc == PC_EUL_LAST) begin
            pc <= PC_PROD_FIRST;
          end else if (pc == PC_PROD_LAST) begin
            norm_quat <= 1'b1;
            state     <= S_NM0;
          end else begin
            pc <= pc + 5'd1;
          end
        end
        S_NM0: begin
          mag[0] <= mg0;
          mag[1] <= mg1;
          mag[2] <= mg2;
          mag[3] <= mg3;
          sg     <= {p3[35], p2[35], p1[35], p0[35]};
          mx     <= mg_max;
          if (mg_max == 36'd0) begin
            // degenerate product: fall back to identity
            o_x   <= '0;
            o_y   <= '0;
            o_z   <= '0;
            o_w   <= 32'sd1073741824;
            state <= S_OUT;
          end else begin
            state <= S_NSH;
          end
        end
        S_NSH: begin
          if (mx[35:31] != 5'd0) begin
            for (int k = 0; k < 4; k++) mag[k] <= mag[k] >> 1;
            mx <= mx >> 1;
          end else if (mx[35:30] == 6'd0) begin
            for (int k = 0; k < 4; k++) mag[k] <= mag[k] << 1;
            mx <= mx << 1;
          end else begin
            sum_sq <= '0;
            ni     <= 2'd0;
            state  <= S_NSQ;
          end
        end
        S_NSQ: begin
          sum_sq <= sum_sq + prod;
          ni     <= ni + 2'd1;
          if (ni == 2'd3) begin
            rx    <= sum_sq + prod;
            res   <= '0;
            bitv  <= SQRT_BIT0;
            state <= S_NSR;
          end
        end
        S_NSR: begin
          if (rx >= sq_try) begin
            rx  <= rx - sq_try;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            ni    <= 2'd0;
            state <= S_NDI;
          end
        end
        S_NDI: begin
          rem   <= {2'b00, div_num[61:32]};
          quo   <= div_num[31:0];
          cnt   <= '0;
          state <= S_NDV;
        end
        S_NDV: begin
          rem <= div_ge ? 32'(rem2 - {1'b0, res[31:0]}) : rem2[31:0];
          quo <= quo_new;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            nrm[ni] <= sg[ni] ? -$signed(quo_new) : $signed(quo_new);
            if (ni == nlast) begin
              state <= S_NEND;
            end else begin
              ni    <= ni + 2'd1;
              state <= S_NDI;
            end
          end
        end
        S_NEND: begin
          if (norm_quat) begin
            o_x   <= nrm[0];
            o_y   <= nrm[1];
            o_z   <= nrm[2];
            o_w   <= nrm[3];
            state <= S_OUT;
          end else begin
            j     <= 2'd0;
            state <= S_PH0;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            quat_x    <= o_x;
            quat_y    <= o_y;
            quat_z    <= o_z;
            quat_w    <= o_w;
            updated   <= upd_r;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/qra_checker.sv -----
// Port-level checker for quaternion_rotation_accumulator.
// Bound to the top level below; no other dependencies.
module qra_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] quat_x,
  input logic signed [31:0] quat_y,
  input logic signed [31:0] quat_z,
  input logic signed [31:0] quat_w,
  input logic               updated
);

  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("out_valid high right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while one is in work");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quat_w >= -32'sd1073741824 && quat_w <= 32'sd1073741824 &&
                   quat_x >= -32'sd1073741824 && quat_x <= 32'sd1073741824 &&
                   quat_y >= -32'sd1073741824 && quat_y <= 32'sd1073741824 &&
                   quat_z >= -32'sd1073741824 && quat_z <= 32'sd1073741824))
    else $error("result component out of unit range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x) &&
                                $stable(quat_y) && $stable(quat_z) && $stable(updated))
    else $error("stalled result changed");

endmodule

bind quaternion_rotation_accumulator qra_checker u_qra_checker (.*);
